/* rtl/svmk_pkg.sv */
// Shared types, constants and helper functions of the SVM decision engine.
// Used by svmk_cell, svmk_kernel and svm_kernel_decision; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package svmk_pkg;

    // Parameter defaults
    localparam int MAX_ROWS_DEF   = 64;
    localparam int FEATURES_DEF   = 6;
    localparam int DEGREE_CAP_DEF = 8;

    // Fixed widths
    localparam int FEAT_PORTS = 6;       // feature fields carried by an input item
    localparam int DATA_W     = 32;      // Q16.16 word
    localparam int ROW_MAX_W  = 10;      // row index width for the largest store
    localparam int MUL_W      = 33;      // signed multiplier operand
    localparam int PROD_W     = 66;      // signed multiplier product
    localparam int TERM_W     = 50;      // product shifted right by 16
    localparam int SUM_W      = 52;      // sum of up to six feature terms
    localparam int IN_DATA_W  = 232;
    localparam int OUT_DATA_W = 32;
    localparam int CFG_IDX_W  = 3;

    // Kernel select codes
    localparam logic [1:0] KM_RBF  = 2'd0;
    localparam logic [1:0] KM_LIN  = 2'd1;
    localparam logic [1:0] KM_POLY = 2'd2;

    // Item kinds
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAMMA       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_POLY_OFFSET = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POLY_DEGREE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_ROWS = 3'd5;

    // Exponential constants
    localparam int EXP_LO    = -(32 * 65536);
    localparam int EXP_HI    = 11 * 65536;
    localparam int LOG2E_Q16 = 94548;
    localparam int LN2_Q16   = 45426;
    localparam int Q_ONE     = 65536;

    typedef enum logic [1:0] {
        CTL_IDLE,
        CTL_RUN,
        CTL_DONE
    } ctl_state_t;

    typedef enum logic [3:0] {
        K_IDLE,
        K_GD,
        K_Y,
        K_Z,
        K_ZF,
        K_T,
        K_TU,
        K_R,
        K_RU,
        K_SH,
        K_GS,
        K_TB,
        K_PM,
        K_PU,
        K_WK,
        K_ACC
    } ker_state_t;

    // Row token handed from cell to cell
    typedef struct packed {
        logic                 valid;
        logic [ROW_MAX_W-1:0] row;
    } tok_t;

    // Kernel settings seen by the kernel sequencer
    typedef struct packed {
        logic [1:0]               mode;
        logic signed [DATA_W-1:0] gamma;
        logic signed [DATA_W-1:0] offset;
        logic [3:0]               degree;
    } ker_cfg_t;

    // 2^(2^-(idx+1)) in Q2.30
    function automatic logic [30:0] pow2_frac(input logic [2:0] idx);
        logic [30:0] r;
        case (idx)
            3'd0:    r = 31'd1518500250;
            3'd1:    r = 31'd1276901417;
            3'd2:    r = 31'd1170923762;
            3'd3:    r = 31'd1121280436;
            3'd4:    r = 31'd1097253708;
            3'd5:    r = 31'd1085434106;
            3'd6:    r = 31'd1079572136;
            default: r = 31'd1076653033;
        endcase
        return r;
    endfunction

    // Clamp a wide signed value to 32 bits
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v[PROD_W-1:DATA_W-1] == '0 || v[PROD_W-1:DATA_W-1] == '1) begin
            r = v[DATA_W-1:0];
        end else if (v[PROD_W-1]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/svmk_cell.sv */
// One feature cell of the row chain: stores one feature column of the support
// vectors, forms the squared difference or product term and adds it to the sum
// from its left neighbor. Depends on svmk_pkg.
`timescale 1ns / 1ps
`default_nettype none

module svmk_cell #(
    parameter int MAX_ROWS = svmk_pkg::MAX_ROWS_DEF
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic [1:0]                           mode,
    input  wire logic                                 wr_en,
    input  wire logic [svmk_pkg::ROW_MAX_W-1:0]       wr_row,
    input  wire logic signed [svmk_pkg::DATA_W-1:0]   wr_data,
    input  wire logic                                 q_load,
    input  wire logic signed [svmk_pkg::DATA_W-1:0]   q_data,
    input  wire svmk_pkg::tok_t                       tok_in,
    output svmk_pkg::tok_t                            tok_out,
    input  wire logic signed [svmk_pkg::SUM_W-1:0]    sum_in,
    output logic signed [svmk_pkg::SUM_W-1:0]         sum_out
);

    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int DW    = svmk_pkg::DATA_W;
    localparam int MW    = svmk_pkg::MUL_W;
    localparam int PW    = svmk_pkg::PROD_W;
    localparam int TW    = svmk_pkg::TERM_W;
    localparam int SW    = svmk_pkg::SUM_W;

    logic signed [DW-1:0] col_mem [MAX_ROWS];
    logic signed [DW-1:0] q_reg;
    logic signed [DW-1:0] v_reg;
    logic signed [TW-1:0] term_reg;
    logic signed [SW-1:0] sum_reg;
    svmk_pkg::tok_t       tok_reg;

    logic signed [MW-1:0] diff;
    logic signed [MW-1:0] opa;
    logic signed [MW-1:0] opb;
    logic signed [PW-1:0] prod;

    // Write the column on loads, read the row that the token names
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            col_mem[wr_row[ROW_W-1:0]] <= wr_data;
        end
        v_reg <= col_mem[tok_in.row[ROW_W-1:0]];
    end

    // Hold the query feature
    always_ff @(posedge aclk) begin
        if (q_load) begin
            q_reg <= q_data;
        end
    end

    // Squared difference for the radial kernel, plain product otherwise
    always_comb begin
        diff = MW'(q_reg) - MW'(v_reg);
        if (mode == svmk_pkg::KM_RBF) begin
            opa = diff;
            opb = diff;
        end else begin
            opa = MW'(q_reg);
            opb = MW'(v_reg);
        end
        prod = PW'(opa) * PW'(opb);
    end

    // Register the term, then add it to the neighbor's sum
    always_ff @(posedge aclk) begin
        term_reg <= prod[PW-1:16];
        sum_reg  <= SW'(term_reg) + sum_in;
    end

    // Advance the row token
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tok_reg <= '0;
        end else begin
            tok_reg <= tok_in;
        end
    end

    assign tok_out = tok_reg;
    assign sum_out = sum_reg;

endmodule

`default_nettype wire

/* rtl/svmk_kernel.sv */
// Kernel sequencer: turns one row's feature sum into the weighted kernel term
// with a single shared multiplier (exp table steps, polynomial power, weight).
// Depends on svmk_pkg.
`timescale 1ns / 1ps
`default_nettype none

module svmk_kernel #(
    parameter int DEGREE_CAP = svmk_pkg::DEGREE_CAP_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire svmk_pkg::ker_cfg_t                  cfg,
    input  wire logic                                in_valid,
    input  wire logic signed [svmk_pkg::SUM_W-1:0]   in_sum,
    input  wire logic signed [svmk_pkg::DATA_W-1:0]  in_weight,
    output logic                                     in_ready,
    output logic                                     term_valid,
    output logic signed [svmk_pkg::TERM_W-1:0]       term
);

    localparam int DEG_W = $clog2(DEGREE_CAP + 1);
    localparam int DW    = svmk_pkg::DATA_W;
    localparam int MW    = svmk_pkg::MUL_W;
    localparam int PW    = svmk_pkg::PROD_W;
    localparam int SW    = svmk_pkg::SUM_W;

    svmk_pkg::ker_state_t state_reg, state_next;
    logic signed [PW-1:0] prod_reg, prod_next;
    logic signed [SW-1:0] sum_reg, sum_next;
    logic signed [DW-1:0] w_reg, w_next;
    logic signed [DW-1:0] k_reg, k_next;
    logic signed [MW-1:0] y_reg, y_next;
    logic [15:0]          f_reg, f_next;
    logic signed [7:0]    n_reg, n_next;
    logic [31:0]          m_reg, m_next;
    logic [2:0]           j_reg, j_next;
    logic signed [DW-1:0] t_reg, t_next;
    logic signed [DW-1:0] p_reg, p_next;
    logic [DEG_W-1:0]     cnt_reg, cnt_next;

    logic signed [MW-1:0] opa, opb;
    logic [30:0]          d_sat;
    logic signed [DW-1:0] s_sat;
    logic signed [50:0]   y_full;
    logic signed [50:0]   tb_sum;
    logic [23:0]          rl;
    logic signed [7:0]    s_sh;
    logic [7:0]           sh;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= svmk_pkg::K_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        sum_reg  <= sum_next;
        w_reg    <= w_next;
        k_reg    <= k_next;
        y_reg    <= y_next;
        f_reg    <= f_next;
        n_reg    <= n_next;
        m_reg    <= m_next;
        j_reg    <= j_next;
        t_reg    <= t_next;
        p_reg    <= p_next;
        cnt_reg  <= cnt_next;
    end

    // Shared values derived from the registers
    always_comb begin
        d_sat  = (sum_reg > SW'(32'sh7FFF_FFFF)) ? 31'h7FFF_FFFF : sum_reg[30:0];
        s_sat  = svmk_pkg::sat32(PW'(sum_reg));
        y_full = -(51'($signed(prod_reg[PW-1:16])));
        tb_sum = 51'($signed(prod_reg[PW-1:16])) + 51'(cfg.offset);
        rl     = {16'd0, f_reg[7:0]} * 24'(svmk_pkg::LN2_Q16);
        s_sh   = n_reg - 8'sd14;
        sh     = -s_sh;
    end

    // Next state, multiplier operands and register updates
    always_comb begin
        state_next = state_reg;
        sum_next   = sum_reg;
        w_next     = w_reg;
        k_next     = k_reg;
        y_next     = y_reg;
        f_next     = f_reg;
        n_next     = n_reg;
        m_next     = m_reg;
        j_next     = j_reg;
        t_next     = t_reg;
        p_next     = p_reg;
        cnt_next   = cnt_reg;
        opa        = '0;
        opb        = '0;
        case (state_reg)
            svmk_pkg::K_IDLE: begin
                if (in_valid) begin
                    sum_next = in_sum;
                    w_next   = in_weight;
                    case (cfg.mode)
                        svmk_pkg::KM_RBF:  state_next = svmk_pkg::K_GD;
                        svmk_pkg::KM_POLY: state_next = svmk_pkg::K_GS;
                        default: begin
                            k_next     = svmk_pkg::sat32(PW'(in_sum));
                            state_next = svmk_pkg::K_WK;
                        end
                    endcase
                end
            end
            // Radial basis: exponent from gamma times distance
            svmk_pkg::K_GD: begin
                opa        = MW'(cfg.gamma);
                opb        = {2'b00, d_sat};
                state_next = svmk_pkg::K_Y;
            end
            svmk_pkg::K_Y: begin
                if (y_full < 51'(svmk_pkg::EXP_LO)) begin
                    k_next     = '0;
                    state_next = svmk_pkg::K_WK;
                end else if (y_full > 51'(svmk_pkg::EXP_HI)) begin
                    k_next     = 32'sh7FFF_FFFF;
                    state_next = svmk_pkg::K_WK;
                end else begin
                    y_next     = y_full[MW-1:0];
                    state_next = svmk_pkg::K_Z;
                end
            end
            svmk_pkg::K_Z: begin
                opa        = y_reg;
                opb        = MW'(svmk_pkg::LOG2E_Q16);
                state_next = svmk_pkg::K_ZF;
            end
            // Split into integer and fraction of the base-2 exponent
            svmk_pkg::K_ZF: begin
                f_next     = prod_reg[31:16];
                n_next     = prod_reg[39:32];
                m_next     = 32'h4000_0000;
                j_next     = '0;
                state_next = svmk_pkg::K_T;
            end
            // Scale by the table entry for each set fraction bit
            svmk_pkg::K_T: begin
                if (f_reg[{1'b1, ~j_reg}]) begin
                    opa        = {1'b0, m_reg};
                    opb        = {2'b00, svmk_pkg::pow2_frac(j_reg)};
                    state_next = svmk_pkg::K_TU;
                end else if (j_reg == 3'd7) begin
                    state_next = svmk_pkg::K_R;
                end else begin
                    j_next = j_reg + 3'd1;
                end
            end
            svmk_pkg::K_TU: begin
                m_next = prod_reg[61:30];
                if (j_reg == 3'd7) begin
                    state_next = svmk_pkg::K_R;
                end else begin
                    j_next     = j_reg + 3'd1;
                    state_next = svmk_pkg::K_T;
                end
            end
            // Linear correction for the low fraction bits
            svmk_pkg::K_R: begin
                opa        = {1'b0, m_reg};
                opb        = {9'd0, rl};
                state_next = svmk_pkg::K_RU;
            end
            svmk_pkg::K_RU: begin
                m_next     = m_reg + prod_reg[63:32];
                state_next = svmk_pkg::K_SH;
            end
            // Apply the integer exponent and clamp
            svmk_pkg::K_SH: begin
                if (s_sh > 8'sd1) begin
                    k_next = 32'sh7FFF_FFFF;
                end else if (s_sh == 8'sd1) begin
                    k_next = (m_reg[31:30] != 2'b00) ? 32'sh7FFF_FFFF : {m_reg[30:0], 1'b0};
                end else if (s_sh == 8'sd0) begin
                    k_next = m_reg[31] ? 32'sh7FFF_FFFF : m_reg;
                end else begin
                    k_next = m_reg >> sh;
                end
                state_next = svmk_pkg::K_WK;
            end
            // Polynomial: base from gamma times dot product
            svmk_pkg::K_GS: begin
                opa        = MW'(cfg.gamma);
                opb        = MW'(s_sat);
                state_next = svmk_pkg::K_TB;
            end
            svmk_pkg::K_TB: begin
                t_next = svmk_pkg::sat32(PW'(tb_sum));
                p_next = DW'(svmk_pkg::Q_ONE);
                if (32'(cfg.degree) > DEGREE_CAP) begin
                    cnt_next = DEG_W'(DEGREE_CAP);
                end else begin
                    cnt_next = DEG_W'(cfg.degree);
                end
                state_next = svmk_pkg::K_PM;
            end
            svmk_pkg::K_PM: begin
                if (cnt_reg == '0) begin
                    k_next     = p_reg;
                    state_next = svmk_pkg::K_WK;
                end else begin
                    opa        = MW'(p_reg);
                    opb        = MW'(t_reg);
                    state_next = svmk_pkg::K_PU;
                end
            end
            svmk_pkg::K_PU: begin
                p_next     = svmk_pkg::sat32(PW'($signed(prod_reg[PW-1:16])));
                cnt_next   = cnt_reg - 1'b1;
                state_next = svmk_pkg::K_PM;
            end
            // Weight the kernel value
            svmk_pkg::K_WK: begin
                opa        = MW'(w_reg);
                opb        = MW'(k_reg);
                state_next = svmk_pkg::K_ACC;
            end
            svmk_pkg::K_ACC: begin
                state_next = svmk_pkg::K_IDLE;
            end
            default: begin
                state_next = svmk_pkg::K_IDLE;
            end
        endcase
        prod_next = PW'(opa) * PW'(opb);
    end

    assign in_ready   = (state_reg == svmk_pkg::K_IDLE);
    assign term_valid = (state_reg == svmk_pkg::K_ACC);
    assign term       = prod_reg[PW-1:16];

endmodule

`default_nettype wire

/* rtl/svm_kernel_decision.sv */
// Top level of the SVM decision engine: stream ports, configuration registers,
// weight store, row sequencing and accumulation. Depends on svmk_pkg,
// svmk_cell and svmk_kernel.
//
// Usage: the s_ channel carries load items (s_tuser = 0) that write one support
// vector and its weight at a row, and query items (s_tuser = 1) that yield one
// score item on the m_ channel. The user must see that the cfg_ channel writes
// registers only while idle; the block itself does not enforce it. A load gives
// no result. A query streams each active row through a chain of FEATURES cells
// into a kernel sequencer with one shared multiplier; rows overlap with the
// chain, so the next row runs through the cells while the kernel works on the
// last. The next item is taken while the result register still waits on
// m_tready; a stalled result holds its data. Reset clears the configuration
// registers and control state; the stores hold nothing defined until loaded.
`timescale 1ns / 1ps
`default_nettype none

module svm_kernel_decision #(
    parameter int MAX_ROWS   = svmk_pkg::MAX_ROWS_DEF,
    parameter int FEATURES   = svmk_pkg::FEATURES_DEF,
    parameter int DEGREE_CAP = svmk_pkg::DEGREE_CAP_DEF
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // row_index[5:0], feat0..feat5 [197:6], dual_weight[229:198], zero pad
    input  wire logic [svmk_pkg::IN_DATA_W-1:0]        s_tdata,
    // kind[0]
    input  wire logic [0:0]                            s_tuser,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // score[31:0]
    output logic [svmk_pkg::OUT_DATA_W-1:0]            m_tdata,
    // positive[0]
    output logic [0:0]                                 m_tuser,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [svmk_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [svmk_pkg::DATA_W-1:0]           cfg_data
);

    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CNT_W = $clog2(MAX_ROWS + 1);
    localparam int DW    = svmk_pkg::DATA_W;
    localparam int PW    = svmk_pkg::PROD_W;
    localparam int TW    = svmk_pkg::TERM_W;
    localparam int SW    = svmk_pkg::SUM_W;
    localparam int RMW   = svmk_pkg::ROW_MAX_W;
    localparam int ACC_W = TW + ROW_W + 1;

    // Configuration registers
    logic [1:0]           kernel_mode_reg;
    logic signed [DW-1:0] gamma_reg;
    logic signed [DW-1:0] poly_offset_reg;
    logic [3:0]           poly_degree_reg;
    logic signed [DW-1:0] bias_reg;
    logic [6:0]           active_rows_reg;

    // Control
    svmk_pkg::ctl_state_t state_reg, state_next;
    logic [CNT_W-1:0]     rows_reg;
    logic [CNT_W-1:0]     issued_reg;
    logic [CNT_W-1:0]     done_reg;
    logic                 inflight_reg;
    logic [1:0]           tail_reg;
    logic                 hold_valid_reg;
    logic signed [SW-1:0] hold_sum_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [DW-1:0] w_mem [MAX_ROWS];
    logic signed [DW-1:0] w_rd_reg;
    logic                 m_tvalid_reg;
    logic [svmk_pkg::OUT_DATA_W-1:0] m_tdata_reg;
    logic                 m_tuser_reg;

    // Input fields
    logic [5:0]           in_row;
    logic signed [DW-1:0] in_feat [svmk_pkg::FEAT_PORTS];
    logic signed [DW-1:0] in_weight;
    logic                 s_acc, load_acc, query_acc, row_ok;
    logic                 issue, take, out_load;
    logic [CNT_W-1:0]     rows_sel;
    logic signed [DW-1:0] score;

    // Chain wiring
    svmk_pkg::tok_t       tok [FEATURES+1];
    logic signed [SW-1:0] sums [FEATURES+1];
    svmk_pkg::ker_cfg_t   ker_cfg;
    logic                 ker_ready;
    logic                 term_valid;
    logic signed [TW-1:0] term;

    // Unpack the input item
    always_comb begin
        in_row    = s_tdata[5:0];
        for (int i = 0; i < svmk_pkg::FEAT_PORTS; i++) begin
            in_feat[i] = s_tdata[6 + DW*i +: DW];
        end
        in_weight = s_tdata[6 + DW*svmk_pkg::FEAT_PORTS +: DW];
    end

    assign s_tready  = (state_reg == svmk_pkg::CTL_IDLE);
    assign s_acc     = s_tvalid && s_tready;
    assign load_acc  = s_acc && (s_tuser[0] == svmk_pkg::KIND_LOAD);
    assign query_acc = s_acc && (s_tuser[0] == svmk_pkg::KIND_QUERY);
    assign row_ok    = (32'(in_row) < MAX_ROWS);
    assign cfg_ready = 1'b1;

    // Rows used by a query
    always_comb begin
        if (kernel_mode_reg != svmk_pkg::KM_RBF && kernel_mode_reg != svmk_pkg::KM_LIN &&
            kernel_mode_reg != svmk_pkg::KM_POLY) begin
            rows_sel = '0;
        end else if (32'(active_rows_reg) > MAX_ROWS) begin
            rows_sel = CNT_W'(MAX_ROWS);
        end else begin
            rows_sel = CNT_W'(active_rows_reg);
        end
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kernel_mode_reg <= '0;
            gamma_reg       <= '0;
            poly_offset_reg <= '0;
            poly_degree_reg <= '0;
            bias_reg        <= '0;
            active_rows_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                svmk_pkg::REG_KERNEL_MODE: kernel_mode_reg <= cfg_data[1:0];
                svmk_pkg::REG_GAMMA:       gamma_reg       <= cfg_data;
                svmk_pkg::REG_POLY_OFFSET: poly_offset_reg <= cfg_data;
                svmk_pkg::REG_POLY_DEGREE: poly_degree_reg <= cfg_data[3:0];
                svmk_pkg::REG_BIAS:        bias_reg        <= cfg_data;
                svmk_pkg::REG_ACTIVE_ROWS: active_rows_reg <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // Issue one row at a time; the next goes once the kernel took the last
    assign issue    = (state_reg == svmk_pkg::CTL_RUN) && !inflight_reg &&
                      (issued_reg != rows_reg);
    assign take     = hold_valid_reg && ker_ready;
    assign out_load = (state_reg == svmk_pkg::CTL_DONE) && (!m_tvalid_reg || m_tready);

    // Control state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            svmk_pkg::CTL_IDLE: begin
                if (query_acc) begin
                    state_next = svmk_pkg::CTL_RUN;
                end
            end
            svmk_pkg::CTL_RUN: begin
                if (done_reg == rows_reg) begin
                    state_next = svmk_pkg::CTL_DONE;
                end
            end
            svmk_pkg::CTL_DONE: begin
                if (out_load) begin
                    state_next = svmk_pkg::CTL_IDLE;
                end
            end
            default: begin
                state_next = svmk_pkg::CTL_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= svmk_pkg::CTL_IDLE;
            rows_reg       <= '0;
            issued_reg     <= '0;
            done_reg       <= '0;
            inflight_reg   <= 1'b0;
            tail_reg       <= '0;
            hold_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            tail_reg  <= {tail_reg[0], tok[FEATURES].valid};
            if (query_acc) begin
                rows_reg   <= rows_sel;
                issued_reg <= '0;
                done_reg   <= '0;
            end else begin
                if (issue) begin
                    issued_reg <= issued_reg + 1'b1;
                end
                if (term_valid) begin
                    done_reg <= done_reg + 1'b1;
                end
            end
            if (issue) begin
                inflight_reg <= 1'b1;
            end else if (take) begin
                inflight_reg <= 1'b0;
            end
            if (tail_reg[1]) begin
                hold_valid_reg <= 1'b1;
            end else if (take) begin
                hold_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the chain result until the kernel takes it
    always_ff @(posedge aclk) begin
        if (tail_reg[1]) begin
            hold_sum_reg <= sums[FEATURES];
        end
    end

    // Weight store
    always_ff @(posedge aclk) begin
        if (load_acc && row_ok) begin
            w_mem[in_row[ROW_W-1:0]] <= in_weight;
        end
        if (issue) begin
            w_rd_reg <= w_mem[issued_reg[ROW_W-1:0]];
        end
    end

    // Accumulate weighted kernel terms over the bias
    always_ff @(posedge aclk) begin
        if (query_acc) begin
            acc_reg <= ACC_W'(bias_reg);
        end else if (term_valid) begin
            acc_reg <= acc_reg + ACC_W'(term);
        end
    end

    // Feature cell chain
    assign tok[0].valid = issue;
    assign tok[0].row   = RMW'(issued_reg);
    assign sums[0]      = '0;

    for (genvar g = 0; g < FEATURES; g++) begin : g_cell
        svmk_cell #(
            .MAX_ROWS (MAX_ROWS)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .mode    (kernel_mode_reg),
            .wr_en   (load_acc && row_ok),
            .wr_row  (RMW'(in_row)),
            .wr_data (in_feat[g]),
            .q_load  (query_acc),
            .q_data  (in_feat[g]),
            .tok_in  (tok[g]),
            .tok_out (tok[g+1]),
            .sum_in  (sums[g]),
            .sum_out (sums[g+1])
        );
    end

    // Kernel sequencer
    assign ker_cfg.mode   = kernel_mode_reg;
    assign ker_cfg.gamma  = gamma_reg;
    assign ker_cfg.offset = poly_offset_reg;
    assign ker_cfg.degree = poly_degree_reg;

    svmk_kernel #(
        .DEGREE_CAP (DEGREE_CAP)
    ) u_kernel (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (ker_cfg),
        .in_valid   (hold_valid_reg),
        .in_sum     (hold_sum_reg),
        .in_weight  (w_rd_reg),
        .in_ready   (ker_ready),
        .term_valid (term_valid),
        .term       (term)
    );

    // Result register
    assign score = svmk_pkg::sat32(PW'(acc_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= score;
            m_tuser_reg <= !score[DW-1];
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

endmodule

`default_nettype wire
